>>> src/mols_pkg.sv
// Shared constants and controller/datapath handshake types for the median unit.
// No dependencies; used by mols_ctrl, mols_dp and median_of_loaded_set_unit.
`timescale 1ns / 1ps

package mols_pkg;

    localparam int DEPTH_DEF   = 128;
    localparam int SAMPLE_W    = 32;
    localparam int MEDIAN_W    = 33;
    localparam int SIZE_W      = 8;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // accepting samples
        logic sort_init;   // pass length <= fill count
        logic rd_first;    // read entry 0
        logic take_first;  // carry <= entry 0, read entry 1
        logic run;         // compare/swap, write lower, read next
        logic pass_end;    // write carry to last slot of the pass
        logic med_lo;      // read lower middle entry
        logic med_hi;      // hold lower, read upper middle entry
        logic med_done;    // load result register, clear the set
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic n_ge2;       // at least two samples stored
        logic more;        // pass not finished
        logic len_ge3;     // another pass follows this one
        logic out_busy;    // result register still held
    } sts_t;

endpackage

>>> src/mols_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mols_ctrl.sv
// Controller FSM: load, bubble-sort passes, median read-out.
// Depends on mols_pkg for the command and status types.
`timescale 1ns / 1ps

module mols_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_accept,
    input  logic          in_last,
    input  mols_pkg::sts_t sts,
    output mols_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_RD0   = 4'd2;
    localparam logic [3:0] ST_FIRST = 4'd3;
    localparam logic [3:0] ST_RUN   = 4'd4;
    localparam logic [3:0] ST_PEND  = 4'd5;
    localparam logic [3:0] ST_MLO   = 4'd6;
    localparam logic [3:0] ST_MHI   = 4'd7;
    localparam logic [3:0] ST_MSUM  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (in_accept && in_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.sort_init = 1'b1;
                state_next    = sts.n_ge2 ? ST_RD0 : ST_MLO;
            end
            ST_RD0:
            begin
                cmd.rd_first = 1'b1;
                state_next   = ST_FIRST;
            end
            ST_FIRST:
            begin
                cmd.take_first = 1'b1;
                state_next     = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
                if (!sts.more)
                begin
                    state_next = ST_PEND;
                end
            end
            ST_PEND:
            begin
                cmd.pass_end = 1'b1;
                state_next   = sts.len_ge3 ? ST_RD0 : ST_MLO;
            end
            ST_MLO:
            begin
                cmd.med_lo = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.med_hi = 1'b1;
                state_next = ST_MSUM;
            end
            ST_MSUM:
            begin
                // wait for the result slot to free up
                if (!sts.out_busy)
                begin
                    cmd.med_done = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/mols_dp.sv
// Datapath: sample store, fill count, compare/swap carry, median adder, result register.
// Depends on mols_pkg and mols_ram.
`timescale 1ns / 1ps

module mols_dp #(
    parameter int DEPTH = mols_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mols_pkg::cmd_t                    cmd,
    input  logic                              in_accept,
    input  logic [mols_pkg::SAMPLE_W-1:0]     sample,
    input  logic                              out_ready,
    output mols_pkg::sts_t                    sts,
    output logic                              out_valid,
    output logic [mols_pkg::MEDIAN_W-1:0]     median_doubled,
    output logic [mols_pkg::SIZE_W-1:0]       set_size,
    output logic                              overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = mols_pkg::SAMPLE_W;

    logic [CW-1:0] fill_reg;
    logic          dropped_reg;
    logic [CW-1:0] len_reg;
    logic [AW-1:0] k_reg;
    logic [SW-1:0] carry_reg;
    logic [SW-1:0] lo_reg;
    logic          out_valid_reg;
    logic [mols_pkg::MEDIAN_W-1:0] med_reg;
    logic [mols_pkg::SIZE_W-1:0]   size_reg;
    logic                          ovf_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [SW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [SW-1:0] rdata;

    logic          full;
    logic          swap;
    logic [SW-1:0] small_val;
    logic [SW-1:0] large_val;
    logic [CW-1:0] half;
    logic [CW-1:0] lo_idx;
    logic [CW-1:0] len_m1;
    logic [AW-1:0] k_m1;
    logic [AW-1:0] k_p1;
    logic [mols_pkg::MEDIAN_W-1:0] med_sum;
    logic [CW+7:0] size_ext;

    assign full      = (fill_reg == CW'(DEPTH));
    assign swap      = $signed(carry_reg) > $signed(rdata);
    assign small_val = swap ? rdata : carry_reg;
    assign large_val = swap ? carry_reg : rdata;
    assign half      = fill_reg >> 1;
    // odd count: both reads hit the middle entry, so the sum is twice it
    assign lo_idx    = fill_reg[0] ? half : half - CW'(1);
    assign len_m1    = len_reg - CW'(1);
    assign k_m1      = k_reg - AW'(1);
    assign k_p1      = k_reg + AW'(1);
    assign med_sum   = {lo_reg[SW-1], lo_reg} + {rdata[SW-1], rdata};
    assign size_ext  = {8'b0, fill_reg};

    assign sts.n_ge2    = (fill_reg >= CW'(2));
    assign sts.more     = ((CW'(k_reg) + CW'(1)) < len_reg);
    assign sts.len_ge3  = (len_reg >= CW'(3));
    assign sts.out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        we    = 1'b0;
        waddr = fill_reg[AW-1:0];
        wdata = sample;
        re    = 1'b0;
        raddr = '0;
        if (in_accept && !full)
        begin
            we = 1'b1;
        end
        if (cmd.rd_first)
        begin
            re = 1'b1;
        end
        if (cmd.take_first)
        begin
            re    = 1'b1;
            raddr = AW'(1);
        end
        if (cmd.run)
        begin
            we    = 1'b1;
            waddr = k_m1;
            wdata = small_val;
            re    = 1'b1;
            raddr = k_p1;
        end
        if (cmd.pass_end)
        begin
            we    = 1'b1;
            waddr = len_m1[AW-1:0];
            wdata = carry_reg;
        end
        if (cmd.med_lo)
        begin
            re    = 1'b1;
            raddr = lo_idx[AW-1:0];
        end
        if (cmd.med_hi)
        begin
            re    = 1'b1;
            raddr = half[AW-1:0];
        end
    end

    mols_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
            if (cmd.sort_init)
            begin
                len_reg <= fill_reg;
            end
            if (cmd.pass_end)
            begin
                len_reg <= len_m1;
            end
            if (cmd.take_first)
            begin
                k_reg <= AW'(1);
            end
            if (cmd.run)
            begin
                k_reg <= k_p1;
            end
            if (cmd.med_done)
            begin
                fill_reg      <= '0;
                dropped_reg   <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_first)
        begin
            carry_reg <= rdata;
        end
        if (cmd.run)
        begin
            carry_reg <= large_val;
        end
        if (cmd.med_hi)
        begin
            lo_reg <= rdata;
        end
        if (cmd.med_done)
        begin
            med_reg  <= med_sum;
            size_reg <= size_ext[7:0];
            ovf_reg  <= dropped_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = med_reg;
    assign set_size       = size_reg;
    assign overflow       = ovf_reg;

endmodule

>>> src/median_of_loaded_set_unit.sv
// Samples load at one item per cycle while in the load state. After the item marked last, the n
// stored samples are bubble-sorted (one RAM read and write per compare/swap step), then the lower
// and upper middle entries are read and, once the result slot is free, the result register
// loads; loading of the next set may overlap a result that is still waiting. Reset (rst_n, async,
// active low) empties the set and the result register; store contents are left as they were.
`timescale 1ns / 1ps

module median_of_loaded_set_unit #(
    parameter int DEPTH = mols_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mols_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] sample
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mols_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [32:0] median_doubled, [40:33] set_size
    output logic                                m_axis_tuser   // [0] overflow
);

    mols_pkg::cmd_t cmd;
    mols_pkg::sts_t sts;

    logic                              in_accept;
    logic [mols_pkg::MEDIAN_W-1:0]     median_doubled;
    logic [mols_pkg::SIZE_W-1:0]       set_size;

    assign s_axis_tready = cmd.load;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    mols_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_last   (s_axis_tlast),
        .sts       (sts),
        .cmd       (cmd)
    );

    mols_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_accept      (in_accept),
        .sample         (s_axis_tdata[mols_pkg::SAMPLE_W-1:0]),
        .out_ready      (m_axis_tready),
        .sts            (sts),
        .out_valid      (m_axis_tvalid),
        .median_doubled (median_doubled),
        .set_size       (set_size),
        .overflow       (m_axis_tuser)
    );

    assign m_axis_tdata = {{(mols_pkg::OUT_TDATA_W - mols_pkg::MEDIAN_W - mols_pkg::SIZE_W){1'b0}},
                           set_size, median_doubled};

`ifndef SYNTHESIS
    // at most one controller command at a time
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("more than one datapath command active");

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n) cmd.med_done |-> !sts.out_busy)
        else $error("result loaded while previous result held");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.med_done |=> m_axis_tvalid)
        else $error("result not presented after median completion");

    // samples are only taken while loading
    assert property (@(posedge clk) disable iff (!rst_n)
                     (cmd.run || cmd.pass_end || cmd.med_hi) |-> !s_axis_tready)
        else $error("input accepted during sort or read-out");
`endif

endmodule
